@@ design/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg: shared types, widths and helpers for the point projection block
// Field widths, register codes and the restoring division step.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COMP_W = 21;                  // packed coordinate component
	localparam int CFG_W  = 3 * COMP_W;          // packed vector register
	localparam int IDX_SEL_W = 3;                // configuration index
	localparam int D_W    = COMP_W + 1;          // point minus eye
	localparam int PROD_W = D_W + COMP_W;        // one component product
	localparam int DOT_W  = PROD_W + 2;          // sum of three products
	localparam int SIZE_W = 11;                  // width / height register
	localparam int Q_W    = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
	localparam int NUM_W  = DOT_W + Q_W;         // pixel numerator / shifted divisor
	localparam int POW_W  = 16;
	localparam int CDIV_W = POW_W + Q_W;         // colour numerator / shifted divisor
	localparam int PIX_W  = 20;
	localparam int BYTE_W = 8;

	localparam logic [CDIV_W-1:0] COLOR_FULL = CDIV_W'(255);
	localparam logic [BYTE_W-1:0] COLOR_GREY = BYTE_W'(127);

	localparam logic [IDX_SEL_W-1:0] REG_EYE     = 3'd0;
	localparam logic [IDX_SEL_W-1:0] REG_RIGHT   = 3'd1;
	localparam logic [IDX_SEL_W-1:0] REG_UP      = 3'd2;
	localparam logic [IDX_SEL_W-1:0] REG_VIEW    = 3'd3;
	localparam logic [IDX_SEL_W-1:0] REG_FORWARD = 3'd4;
	localparam logic [IDX_SEL_W-1:0] REG_WIDTH   = 3'd5;
	localparam logic [IDX_SEL_W-1:0] REG_HEIGHT  = 3'd6;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [NUM_W-1:0] dsh;
		logic [Q_W-1:0]   q;
	} pdiv_t;

	typedef struct packed {
		logic [CDIV_W-1:0] rem;
		logic [CDIV_W-1:0] dsh;
		logic [Q_W-1:0]    q;
	} cdiv_t;

	// values that ride along the division stages
	typedef struct packed {
		logic [SIZE_W-1:0] w;
		logic [Q_W-1:0]    hm1;
		logic              zero_pow;
	} side_t;

	function automatic pdiv_t pdiv_step(input pdiv_t s);
		pdiv_t r;
		r = s;
		if (s.rem >= s.dsh) begin
			r.rem = s.rem - s.dsh;
			r.q   = {s.q[Q_W-2:0], 1'b1};
		end else begin
			r.q   = {s.q[Q_W-2:0], 1'b0};
		end
		r.dsh = s.dsh >> 1;
		return r;
	endfunction

	function automatic cdiv_t cdiv_step(input cdiv_t s);
		cdiv_t r;
		r = s;
		if (s.rem >= s.dsh) begin
			r.rem = s.rem - s.dsh;
			r.q   = {s.q[Q_W-2:0], 1'b1};
		end else begin
			r.q   = {s.q[Q_W-2:0], 1'b0};
		end
		r.dsh = s.dsh >> 1;
		return r;
	endfunction

endpackage

@@ design/pps_divider.sv @@
// ----------------------------------------------------------------------------
// pps_divider: pipelined restoring divider for pixel and colour quotients
// One quotient bit per stage; column, row and three colour channels in step.
// ----------------------------------------------------------------------------
module pps_divider import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  nx,
	input  logic [NUM_W-1:0]  ny,
	input  logic [DOT_W-1:0]  den,
	input  logic [CDIV_W-1:0] cnum [3],
	input  logic [POW_W-1:0]  cmax,
	input  side_t             side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    qx,
	output logic [Q_W-1:0]    qy,
	output logic [Q_W-1:0]    qc [3],
	output side_t             side_out
);

	pdiv_t x0, y0;
	cdiv_t c0 [3];
	pdiv_t xd_s6 [Q_W];
	pdiv_t yd_s6 [Q_W];
	cdiv_t cd_s6 [Q_W][3];
	side_t sd_s6 [Q_W];
	logic  vld_s6 [Q_W];

	// seed: divisor shifted to the top quotient bit
	always_comb begin
		x0.rem = nx;
		x0.dsh = NUM_W'(den) << (Q_W - 1);
		x0.q   = '0;
		y0.rem = ny;
		y0.dsh = NUM_W'(den) << (Q_W - 1);
		y0.q   = '0;
		for (int k = 0; k < 3; k++) begin
			c0[k].rem = cnum[k];
			c0[k].dsh = CDIV_W'(cmax) << (Q_W - 1);
			c0[k].q   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Q_W; i++) vld_s6[i] <= 1'b0;
		end else if (adv) begin
			vld_s6[0] <= in_vld;
			for (int i = 1; i < Q_W; i++) vld_s6[i] <= vld_s6[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xd_s6[0] <= pdiv_step(x0);
			yd_s6[0] <= pdiv_step(y0);
			sd_s6[0] <= side_in;
			for (int k = 0; k < 3; k++) cd_s6[0][k] <= cdiv_step(c0[k]);
			for (int i = 1; i < Q_W; i++) begin
				xd_s6[i] <= pdiv_step(xd_s6[i-1]);
				yd_s6[i] <= pdiv_step(yd_s6[i-1]);
				sd_s6[i] <= sd_s6[i-1];
				for (int k = 0; k < 3; k++) cd_s6[i][k] <= cdiv_step(cd_s6[i-1][k]);
			end
		end
	end

	assign out_vld  = vld_s6[Q_W-1];
	assign qx       = xd_s6[Q_W-1].q;
	assign qy       = yd_s6[Q_W-1].q;
	assign side_out = sd_s6[Q_W-1];
	always_comb begin
		for (int k = 0; k < 3; k++) qc[k] = cd_s6[Q_W-1][k].q;
	end

endmodule

@@ design/point_projection_splat.sv @@
// ----------------------------------------------------------------------------
// point_projection_splat: pinhole projection of one point to a pixel word
// Projects a 3D point through the camera in the registers and emits a
// flipped pixel index with a max-normalized colour, or drops the point.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  input     in_valid/in_stall, point_*, power_*       in
//  output    out_valid/out_stall, pixel_index, rgb     out
//  config    cfg_write, cfg_index, cfg_data            in
//
//  One word enters per cycle while the pipe is not held; the stages are: offset,
//  products, dot sums, range test, scale multiply, ten restoring division stages
//  (one quotient bit each) and the index multiply-add in the output register.
//  Reset clears the valid bits and loads the camera registers (size 1024).
//  The whole pipe holds while the output word is stalled; empty output
//  frees it, so in_stall follows out_stall only when the last stage is full.
//  Dropped points leave a bubble and never reach the output.
// ----------------------------------------------------------------------------
module point_projection_splat import pps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [IDX_SEL_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [COMP_W-1:0] point_x,
	input  logic signed [COMP_W-1:0] point_y,
	input  logic signed [COMP_W-1:0] point_z,
	input  logic [POW_W-1:0]        power_red,
	input  logic [POW_W-1:0]        power_green,
	input  logic [POW_W-1:0]        power_blue,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [PIX_W-1:0]        pixel_index,
	output logic [BYTE_W-1:0]       red,
	output logic [BYTE_W-1:0]       green,
	output logic [BYTE_W-1:0]       blue
);

	// camera registers
	logic [CFG_W-1:0]  eye_q, right_q, up_q, view_q, fwd_q;
	logic [SIZE_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q    <= '0;
			right_q  <= '0;
			up_q     <= '0;
			view_q   <= '0;
			fwd_q    <= '0;
			width_q  <= SIZE_W'(1024);
			height_q <= SIZE_W'(1024);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_EYE:     eye_q    <= cfg_data;
				REG_RIGHT:   right_q  <= cfg_data;
				REG_UP:      up_q     <= cfg_data;
				REG_VIEW:    view_q   <= cfg_data;
				REG_FORWARD: fwd_q    <= cfg_data;
				REG_WIDTH:   width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipe unless a finished word is held at the output
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic signed [COMP_W-1:0] pt [3];
	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// stage 1: offset from the eye
	logic                   v_s1;
	logic signed [D_W-1:0]  d_s1 [3];
	logic [POW_W-1:0]       pow_s1 [3];

	// stage 2: component products
	logic                     v_s2;
	logic signed [PROD_W-1:0] pf_s2 [3], pa_s2 [3], pb_s2 [3], pc_s2 [3];
	logic [POW_W-1:0]         pow_s2 [3];

	// stage 3: dot sums
	logic                    v_s3;
	logic signed [DOT_W-1:0] f_s3, a_s3, b_s3, c_s3;
	logic [POW_W-1:0]        pow_s3 [3];

	// stage 4: range test and division operands
	logic              keep;
	logic              v_s4;
	logic [DOT_W-1:0]  ra_s4, rb_s4, den_s4;
	logic [Q_W-1:0]    wm1_s4, hm1_s4;
	logic [SIZE_W-1:0] w_s4;
	logic [CDIV_W-1:0] cnum_s4 [3];
	logic [POW_W-1:0]  m_s4;

	// stage 5: scaled numerators
	logic              v_s5;
	logic [NUM_W-1:0]  nx_s5, ny_s5;
	logic [DOT_W-1:0]  den_s5;
	logic [CDIV_W-1:0] cnum_s5 [3];
	logic [POW_W-1:0]  m_s5;
	side_t             side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= keep;
			v_s5 <= v_s4;
		end
	end

	// saturate the image size to the framebuffer limits
	logic [SIZE_W-1:0] w_sat, h_sat;
	assign w_sat = (width_q  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_q;
	assign h_sat = (height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q;

	// keep only points in front of the camera and inside the view square, with a nonzero image size
	assign keep = v_s3 && (f_s3 > 0) && (c_s3 > 0) &&
		(a_s3 >= -c_s3) && (a_s3 <= c_s3) && (b_s3 >= -c_s3) && (b_s3 <= c_s3) &&
		(w_sat != '0) && (h_sat != '0);

	logic [POW_W-1:0] m_max;
	always_comb begin
		m_max = pow_s3[0];
		if (pow_s3[1] > m_max) m_max = pow_s3[1];
		if (pow_s3[2] > m_max) m_max = pow_s3[2];
	end

	logic [SIZE_W-1:0] wm1_full, hm1_full;
	assign wm1_full = w_sat - SIZE_W'(1);
	assign hm1_full = h_sat - SIZE_W'(1);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]   <= D_W'(pt[k]) - D_W'($signed(eye_q[COMP_W*k +: COMP_W]));
			end
			pow_s1[0] <= power_red;
			pow_s1[1] <= power_green;
			pow_s1[2] <= power_blue;

			for (int k = 0; k < 3; k++) begin
				pf_s2[k]  <= PROD_W'(d_s1[k]) * PROD_W'($signed(fwd_q[COMP_W*k +: COMP_W]));
				pa_s2[k]  <= PROD_W'(d_s1[k]) * PROD_W'($signed(right_q[COMP_W*k +: COMP_W]));
				pb_s2[k]  <= PROD_W'(d_s1[k]) * PROD_W'($signed(up_q[COMP_W*k +: COMP_W]));
				pc_s2[k]  <= PROD_W'(d_s1[k]) * PROD_W'($signed(view_q[COMP_W*k +: COMP_W]));
				pow_s2[k] <= pow_s1[k];
			end

			f_s3 <= DOT_W'(pf_s2[0]) + DOT_W'(pf_s2[1]) + DOT_W'(pf_s2[2]);
			a_s3 <= DOT_W'(pa_s2[0]) + DOT_W'(pa_s2[1]) + DOT_W'(pa_s2[2]);
			b_s3 <= DOT_W'(pb_s2[0]) + DOT_W'(pb_s2[1]) + DOT_W'(pb_s2[2]);
			c_s3 <= DOT_W'(pc_s2[0]) + DOT_W'(pc_s2[1]) + DOT_W'(pc_s2[2]);
			for (int k = 0; k < 3; k++) pow_s3[k] <= pow_s2[k];

			// offsets into 0..2c, so the quotients land in 0..size-1
			ra_s4  <= DOT_W'(a_s3 + c_s3);
			rb_s4  <= DOT_W'(b_s3 + c_s3);
			den_s4 <= {c_s3[DOT_W-2:0], 1'b0};
			wm1_s4 <= wm1_full[Q_W-1:0];
			hm1_s4 <= hm1_full[Q_W-1:0];
			w_s4   <= w_sat;
			m_s4   <= m_max;
			for (int k = 0; k < 3; k++) cnum_s4[k] <= CDIV_W'(pow_s3[k]) * COLOR_FULL;

			nx_s5            <= NUM_W'(ra_s4) * NUM_W'(wm1_s4);
			ny_s5            <= NUM_W'(rb_s4) * NUM_W'(hm1_s4);
			den_s5           <= den_s4;
			m_s5             <= m_s4;
			side_s5.w        <= w_s4;
			side_s5.hm1      <= hm1_s4;
			side_s5.zero_pow <= (m_s4 == '0);
			for (int k = 0; k < 3; k++) cnum_s5[k] <= cnum_s4[k];
		end
	end

	// stages 6..15: quotient bits
	logic           v_dv;
	logic [Q_W-1:0] qx_dv, qy_dv;
	logic [Q_W-1:0] qc_dv [3];
	side_t          side_dv;

	pps_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s5),
		.nx       (nx_s5),
		.ny       (ny_s5),
		.den      (den_s5),
		.cnum     (cnum_s5),
		.cmax     (m_s5),
		.side_in  (side_s5),
		.out_vld  (v_dv),
		.qx       (qx_dv),
		.qy       (qy_dv),
		.qc       (qc_dv),
		.side_out (side_dv)
	);

	// output stage: flip the row and form the linear index
	logic [SIZE_W+Q_W-1:0] idx_full;
	assign idx_full = (SIZE_W+Q_W)'(side_dv.hm1 - qy_dv) * (SIZE_W+Q_W)'(side_dv.w)
		+ (SIZE_W+Q_W)'(qx_dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_index <= idx_full[PIX_W-1:0];
			red   <= side_dv.zero_pow ? COLOR_GREY : qc_dv[0][BYTE_W-1:0];
			green <= side_dv.zero_pow ? COLOR_GREY : qc_dv[1][BYTE_W-1:0];
			blue  <= side_dv.zero_pow ? COLOR_GREY : qc_dv[2][BYTE_W-1:0];
		end
	end

endmodule

@@ tb/tb_point_projection_splat.sv @@
// ----------------------------------------------------------------------------
// tb_point_projection_splat: self-checking bench for the projection block
// Drives points through the pinhole camera under random idling on both
// channels, predicts the pixel word of each kept point and checks it.
// ----------------------------------------------------------------------------
module tb_point_projection_splat;
	timeunit 1ns;
	timeprecision 1ps;
	import pps_pkg::*;

	typedef struct {
		logic [PIX_W-1:0]  pix;
		logic [BYTE_W-1:0] r;
		logic [BYTE_W-1:0] g;
		logic [BYTE_W-1:0] b;
	} splat_t;

	// scoreboard: camera copy, projection predictor and pending pixel words
	class splat_board;
		logic [CFG_W-1:0]  cam [0:4];
		logic [SIZE_W-1:0] wreg;
		logic [SIZE_W-1:0] hreg;
		splat_t pending[$];
		int errors;
		int kept;

		function new();
			foreach (cam[i]) cam[i] = '0;
			wreg = 11'd1024;
			hreg = 11'd1024;
			errors = 0;
			kept = 0;
		endfunction

		function void write_reg(logic [IDX_SEL_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_WIDTH)
				wreg = val[SIZE_W-1:0];
			else if (idx == REG_HEIGHT)
				hreg = val[SIZE_W-1:0];
			else if (idx <= REG_FORWARD)
				cam[idx] = val;
		endfunction

		function longint axis_dot(longint d[3], logic [CFG_W-1:0] ax);
			longint s;
			s = 0;
			for (int k = 0; k < 3; k++)
				s += d[k] * longint'($signed(ax[k*COMP_W +: COMP_W]));
			return s;
		endfunction

		// note one accepted point; queue its pixel word if it lands
		function void note_point(logic signed [COMP_W-1:0] p[3], logic [POW_W-1:0] pw[3]);
			longint d[3];
			longint f, a, b, c, w, h, px, py, m;
			splat_t e;
			for (int k = 0; k < 3; k++)
				d[k] = longint'(p[k]) - longint'($signed(cam[REG_EYE][k*COMP_W +: COMP_W]));
			f = axis_dot(d, cam[REG_FORWARD]);
			a = axis_dot(d, cam[REG_RIGHT]);
			b = axis_dot(d, cam[REG_UP]);
			c = axis_dot(d, cam[REG_VIEW]);
			if (f <= 0 || c <= 0) return;
			if (a < -c || a > c || b < -c || b > c) return;
			w = (wreg > MAX_WIDTH) ? MAX_WIDTH : wreg;
			h = (hreg > MAX_HEIGHT) ? MAX_HEIGHT : hreg;
			if (w == 0 || h == 0) return;
			px = ((a + c) * (w - 1)) / (2 * c);
			py = ((b + c) * (h - 1)) / (2 * c);
			if (px >= w || py >= h) return;
			e.pix = PIX_W'((h - 1 - py) * w + px);
			m = pw[0];
			if (pw[1] > m) m = pw[1];
			if (pw[2] > m) m = pw[2];
			e.r = (m > 0) ? BYTE_W'((longint'(pw[0]) * 255) / m) : COLOR_GREY;
			e.g = (m > 0) ? BYTE_W'((longint'(pw[1]) * 255) / m) : COLOR_GREY;
			e.b = (m > 0) ? BYTE_W'((longint'(pw[2]) * 255) / m) : COLOR_GREY;
			pending.push_back(e);
			kept++;
		endfunction

		task check_word(splat_t got);
			splat_t e;
			if (pending.size() == 0) begin
				report_err($sformatf("unexpected word pix=%0d", got.pix));
				return;
			end
			e = pending.pop_front();
			if (got.pix !== e.pix)
				report_err($sformatf("pixel_index got %0d exp %0d", got.pix, e.pix));
			if (got.r !== e.r) report_err($sformatf("red got %0d exp %0d", got.r, e.r));
			if (got.g !== e.g) report_err($sformatf("green got %0d exp %0d", got.g, e.g));
			if (got.b !== e.b) report_err($sformatf("blue got %0d exp %0d", got.b, e.b));
		endtask

		task report_err(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [IDX_SEL_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [COMP_W-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [POW_W-1:0] power_red = '0, power_green = '0, power_blue = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [PIX_W-1:0] pixel_index;
	logic [BYTE_W-1:0] red, green, blue;

	splat_board board = new();
	bit send_done = 0;
	int quiet_cycles = 0;
	localparam int QUIET_LIMIT = 4000;
	localparam int FLUSH_CYCLES = 40;

	point_projection_splat u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stall per word, check at the rising edge
	initial begin
		int gap;
		forever begin
			gap = $urandom_range(0, 18);
			if ($urandom_range(0, 3) == 0) gap = 0;
			@(negedge clk);
			out_stall <= (gap != 0);
			repeat (gap) @(negedge clk);
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			board.check_word('{pixel_index, red, green, blue});
		end
	end

	// watchdog: count cycles with no accepted word on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_cfg(logic [IDX_SEL_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_write <= 0;
	endtask

	// drop the input, hold until every expected word has come, then drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (FLUSH_CYCLES) @(negedge clk);
	endtask

	task automatic send_point(logic signed [COMP_W-1:0] x, y, z, logic [POW_W-1:0] r, g, b,
			bit idle_ok = 1);
		int gap;
		logic signed [COMP_W-1:0] p[3];
		logic [POW_W-1:0] pw[3];
		gap = idle_ok ? $urandom_range(0, 18) : 0;
		if ($urandom_range(0, 2) == 0) gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		in_valid <= 1;
		point_x <= x; point_y <= y; point_z <= z;
		power_red <= r; power_green <= g; power_blue <= b;
		do @(posedge clk); while (in_stall);
		p = '{x, y, z};
		pw = '{r, g, b};
		board.note_point(p, pw);
	endtask

	function automatic logic [CFG_W-1:0] pack3(int a, int b, int c);
		return {COMP_W'(c), COMP_W'(b), COMP_W'(a)};
	endfunction

	// a camera at eye looking down +z with modest random tilt, or random registers when wild; Q3.18 unit = 1<<18
	task automatic load_camera(bit wild);
		int s;
		if (wild) begin
			for (int i = 0; i <= REG_FORWARD; i++)
				write_cfg(IDX_SEL_W'(i), CFG_W'({$urandom, $urandom}));
			return;
		end
		s = $urandom_range(1 << 12, 1 << 16);
		write_cfg(REG_EYE, pack3($urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000));
		write_cfg(REG_RIGHT, pack3(s, $urandom_range(0, 512) - 256, 0));
		write_cfg(REG_UP, pack3($urandom_range(0, 512) - 256, s, 0));
		write_cfg(REG_VIEW, pack3(0, 0, s));
		write_cfg(REG_FORWARD, pack3($urandom_range(0, 2000) - 1000,
			$urandom_range(0, 2000) - 1000, 1 << 18));
	endtask

	task automatic random_point();
		logic signed [COMP_W-1:0] x, y, z;
		logic [POW_W-1:0] r, g, b;
		int sel;
		sel = $urandom_range(0, 9);
		z = (sel < 8) ? COMP_W'($urandom_range(256, 400000)) : COMP_W'($urandom);
		x = (sel < 7) ? COMP_W'($signed($urandom_range(0, 800000)) - 400000) : COMP_W'($urandom);
		y = (sel < 7) ? COMP_W'($signed($urandom_range(0, 800000)) - 400000) : COMP_W'($urandom);
		r = POW_W'($urandom); g = POW_W'($urandom); b = POW_W'($urandom);
		if ($urandom_range(0, 15) == 0) begin r = '0; g = '0; b = '0; end
		else if ($urandom_range(0, 7) == 0) begin g = '0; b = POW_W'($urandom_range(0, 3)); end
		send_point(x + COMP_W'($signed(board.cam[REG_EYE][0 +: COMP_W])),
			y + COMP_W'($signed(board.cam[REG_EYE][COMP_W +: COMP_W])),
			z + COMP_W'($signed(board.cam[REG_EYE][2*COMP_W +: COMP_W])), r, g, b);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;

		// directed: identity camera, extremes of coordinates and power
		write_cfg(REG_EYE, '0);
		write_cfg(REG_RIGHT, pack3(1 << 10, 0, 0));
		write_cfg(REG_UP, pack3(0, 1 << 10, 0));
		write_cfg(REG_VIEW, pack3(0, 0, 1 << 10));
		write_cfg(REG_FORWARD, pack3(0, 0, 1 << 18));
		send_point(21'sd0, 21'sd0, 21'sd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(21'sd1000, 21'sd1000, 21'sd1000, 16'd0, 16'd0, 16'd0); // corner, all power zero
		send_point(-21'sd1000, -21'sd1000, 21'sd1000, 16'd1, 16'd0, 16'd0);
		send_point(21'sd1001, 21'sd0, 21'sd1000, 16'd5, 16'd6, 16'd7);    // just outside on x
		send_point(21'sd0, -21'sd1001, 21'sd1000, 16'd5, 16'd6, 16'd7);   // just outside on y
		send_point(21'sd0, 21'sd0, -21'sd1000, 16'd9, 16'd9, 16'd9);      // behind the camera
		send_point(21'sd0, 21'sd0, 21'sd0, 16'd9, 16'd9, 16'd9);          // on the camera
		send_point(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 16'hFFFF, 16'd0, 16'd1);
		send_point(21'h100000, 21'h100000, 21'h0FFFFF, 16'd0, 16'hFFFF, 16'h8000);
		send_point(21'h100000, 21'h0FFFFF, 21'h100000, 16'h8000, 16'd1, 16'hFFFF);
		wait_idle();
		// forward says in front, view axis says behind
		write_cfg(REG_VIEW, pack3(0, 0, -(1 << 10)));
		send_point(21'sd0, 21'sd0, 21'sd1000, 16'd3, 16'd2, 16'd1);
		wait_idle();
		write_cfg(REG_VIEW, pack3(0, 0, 1 << 10));
		write_cfg(REG_WIDTH, '0);                           // zero width drops all
		send_point(21'sd10, 21'sd10, 21'sd1000, 16'd3, 16'd2, 16'd1);
		wait_idle();
		write_cfg(REG_WIDTH, CFG_W'(11'h7FF));              // saturates to maximum
		write_cfg(REG_HEIGHT, CFG_W'(11'h7FF));
		send_point(21'sd999, -21'sd999, 21'sd1000, 16'd3, 16'd2, 16'd1);
		send_point(-21'sd1000, 21'sd1000, 21'sd1000, 16'd3, 16'd2, 16'd1);
		wait_idle();
		write_cfg(REG_WIDTH, CFG_W'(1));
		write_cfg(REG_HEIGHT, '0);
		send_point(21'sd10, 21'sd10, 21'sd1000, 16'd3, 16'd2, 16'd1);
		wait_idle();
		write_cfg(REG_HEIGHT, CFG_W'(1));
		send_point(21'sd10, 21'sd10, 21'sd1000, 16'd3, 16'd2, 16'd1);
		send_point(21'sd1000, -21'sd1000, 21'sd1000, 16'd3, 16'd2, 16'd1);
		wait_idle();

		// random phases through several camera and size settings
		for (int ph = 0; ph < 16; ph++) begin
			wait_idle();
			load_camera(ph == 5 || ph == 11);
			case (ph % 4)
				0: begin
					write_cfg(REG_WIDTH, CFG_W'(1024));
					write_cfg(REG_HEIGHT, CFG_W'(1024));
				end
				1: begin write_cfg(REG_WIDTH, CFG_W'(2)); write_cfg(REG_HEIGHT, CFG_W'(1)); end
				2: begin
					write_cfg(REG_WIDTH, CFG_W'($urandom_range(1, 2047)));
					write_cfg(REG_HEIGHT, CFG_W'($urandom_range(1, 2047)));
				end
				default: begin
					write_cfg(REG_WIDTH, CFG_W'($urandom_range(1, 64)));
					write_cfg(REG_HEIGHT, CFG_W'($urandom_range(1, 64)));
				end
			endcase
			for (int i = 0; i < 96; i++) begin
				// pause once mid-phase until everything has drained
				if (ph == 3 && i == 48) begin
					@(negedge clk);
					in_valid <= 0;
					wait_idle();
				end
				random_point();
			end
		end
		@(negedge clk);
		in_valid <= 0;
		send_done = 1;
	end

	initial begin
		wait (send_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
